>>> rtl/dtpy_pkg.sv
package dtpy_pkg;

  // Field and datapath widths
  localparam int DIR_W            = 32;
  localparam int OUT_W            = 25;
  localparam int FRAC_W           = 16;
  localparam int LANE_W           = 52;
  localparam int ANG_W            = 27;
  localparam int CORDIC_STEPS_DEF = 16;

  // Angles in Q16 degrees
  localparam logic signed [ANG_W-1:0] DEG_90  = 27'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG_180 = 27'sd11796480;
  localparam logic signed [ANG_W-1:0] DEG_270 = 27'sd17694720;
  localparam logic signed [ANG_W-1:0] DEG_360 = 27'sd23592960;

  // 1/K in Q31 for the CORDIC gain
  localparam logic [30:0] INV_GAIN_Q31 = 31'd1304065748;

  // One vectoring lane: the vector and its running angle
  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [ANG_W-1:0]  ang;
  } lane_t;

  // Side data carried alongside the lane
  typedef struct packed {
    logic                    spec;  // x and y both zero
    logic                    zpos;  // z strictly positive
    logic signed [DIR_W-1:0] z;
    logic signed [ANG_W-1:0] yaw;   // finished yaw angle (pitch pass)
  } side_t;

  // atan(2^-i) in Q16 degrees, rounded
  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117304;
      5'd6:    v = 27'sd58666;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      5'd22:   v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Bring an angle into [0, 360) degrees
  function automatic logic [OUT_W-1:0] wrap_deg(input logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W-1:0] a;
    a = ang;
    if (a < 0) a = a + DEG_360;
    if (a >= DEG_360) a = a - DEG_360;
    if (a < 0) a = '0;
    return a[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/direction_to_pitch_yaw.sv
// Channel | Direction | Handshake          | Word
// in_     | input     | in_valid/in_stall  | in_dir_x, in_dir_y, in_dir_z (s32 Q16.16)
// out_    | output    | out_valid/out_stall| out_pitch_angle, out_yaw_angle (u25 Q9.16)
//
// Stages in order: prep, one register per yaw micro-rotation,
// two gain-multiply registers, one per pitch micro-rotation, output register.
// One word enters per cycle while in_stall is low; each stage holds a valid bit and fills bubbles.
// Synchronous active-low reset clears the valid bits only.
// out_stall holds a stage only when it and all later stages are occupied.
module direction_to_pitch_yaw
  import dtpy_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DIR_W-1:0] in_dir_x,
  input  logic signed [DIR_W-1:0] in_dir_y,
  input  logic signed [DIR_W-1:0] in_dir_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_W-1:0]        out_pitch_angle,
  output logic [OUT_W-1:0]        out_yaw_angle
);

  localparam int NSTG  = 2 * CORDIC_STEPS + 4;
  localparam int GAIN  = CORDIC_STEPS + 1;
  localparam int PBASE = CORDIC_STEPS + 3;
  localparam int EXT_W = LANE_W - DIR_W - FRAC_W;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_prev;
  logic [NSTG:0]   rdy;

  lane_t pre_nxt, pre_r;
  side_t pre_side_nxt, pre_side_r;
  lane_t yaw_lane [CORDIC_STEPS+1];
  side_t yaw_side [CORDIC_STEPS+1];
  lane_t pit_lane [CORDIC_STEPS+1];
  side_t pit_side [CORDIC_STEPS+1];

  logic signed [LANE_W-1:0] xs, ys;
  logic [OUT_W-1:0]         pitch_nxt, yaw_nxt, pitch_r, yaw_r;

  // Stage handshake: a stage loads when empty or when the next one moves
  assign rdy[NSTG] = !out_stall;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  assign vld_prev = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) vld_r[k] <= vld_prev[k];
      end
    end
  end

  // Prep: scale to Q32, fold left half-plane onto the right
  always_comb begin
    xs = {{EXT_W{in_dir_x[DIR_W-1]}}, in_dir_x, {FRAC_W{1'b0}}};
    ys = {{EXT_W{in_dir_y[DIR_W-1]}}, in_dir_y, {FRAC_W{1'b0}}};
    if (in_dir_x[DIR_W-1]) begin
      pre_nxt.x   = -xs;
      pre_nxt.y   = -ys;
      pre_nxt.ang = DEG_180;
    end else begin
      pre_nxt.x   = xs;
      pre_nxt.y   = ys;
      pre_nxt.ang = '0;
    end
    pre_side_nxt.spec = (in_dir_x == '0) && (in_dir_y == '0);
    pre_side_nxt.zpos = (in_dir_z > 0);
    pre_side_nxt.z    = in_dir_z;
    pre_side_nxt.yaw  = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pre_r      <= pre_nxt;
      pre_side_r <= pre_side_nxt;
    end
  end

  assign yaw_lane[0] = pre_r;
  assign yaw_side[0] = pre_side_r;

  // Yaw vectoring pass
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_yaw
    dtpy_cordic_stage #(.STEP(i)) u_stage (
      .clk    (clk),
      .ld     (rdy[i+1]),
      .lane_i (yaw_lane[i]),
      .side_i (yaw_side[i]),
      .lane_o (yaw_lane[i+1]),
      .side_o (yaw_side[i+1])
    );
  end

  // Gain correction of the magnitude, z into the pitch lane
  dtpy_gain u_gain (
    .clk    (clk),
    .ld_a   (rdy[GAIN]),
    .ld_b   (rdy[GAIN+1]),
    .lane_i (yaw_lane[CORDIC_STEPS]),
    .side_i (yaw_side[CORDIC_STEPS]),
    .lane_o (pit_lane[0]),
    .side_o (pit_side[0])
  );

  // Pitch vectoring pass
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_pitch
    dtpy_cordic_stage #(.STEP(i)) u_stage (
      .clk    (clk),
      .ld     (rdy[PBASE+i]),
      .lane_i (pit_lane[i]),
      .side_i (pit_side[i]),
      .lane_o (pit_lane[i+1]),
      .side_o (pit_side[i+1])
    );
  end

  // Output: wrap angles, substitute the vertical-vector case
  always_comb begin
    if (pit_side[CORDIC_STEPS].spec) begin
      pitch_nxt = pit_side[CORDIC_STEPS].zpos ? DEG_270[OUT_W-1:0] : DEG_90[OUT_W-1:0];
      yaw_nxt   = '0;
    end else begin
      pitch_nxt = wrap_deg(pit_lane[CORDIC_STEPS].ang);
      yaw_nxt   = wrap_deg(pit_side[CORDIC_STEPS].yaw);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  assign in_stall        = !rdy[0];
  assign out_valid       = vld_r[NSTG-1];
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;

`ifndef SYNTH
  // Input back-pressure only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled with a free stage");

  // Delivered angles lie in [0, 360)
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pitch_angle < DEG_360[OUT_W-1:0]) &&
                   (out_yaw_angle < DEG_360[OUT_W-1:0])))
    else $error("angle out of range");

  // A vertical vector leaves with zero yaw and pitch of 90 or 270
  a_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-2] && rdy[NSTG-1] && pit_side[CORDIC_STEPS].spec) |=>
      ((out_yaw_angle == '0) &&
       ((out_pitch_angle == DEG_90[OUT_W-1:0]) ||
        (out_pitch_angle == DEG_270[OUT_W-1:0]))))
    else $error("vertical vector case wrong");
`endif

endmodule

>>> rtl/dtpy_cordic_stage.sv
module dtpy_cordic_stage
  import dtpy_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  ld,
  input  lane_t lane_i,
  input  side_t side_i,
  output lane_t lane_o,
  output side_t side_o
);

  localparam logic [4:0] SHIFT = 5'(STEP % 32);

  logic signed [LANE_W-1:0] x, y, dx, dy;
  logic signed [ANG_W-1:0]  ang, da;
  lane_t lane_nxt;
  lane_t lane_r;
  side_t side_r;

  // One vectoring micro-rotation, direction from the sign of y
  always_comb begin
    x   = lane_i.x;
    y   = lane_i.y;
    ang = lane_i.ang;
    dx  = y >>> SHIFT;
    dy  = x >>> SHIFT;
    da  = atan_q16(SHIFT);
    if (!y[LANE_W-1]) begin
      lane_nxt.x   = x + dx;
      lane_nxt.y   = y - dy;
      lane_nxt.ang = ang + da;
    end else begin
      lane_nxt.x   = x - dx;
      lane_nxt.y   = y + dy;
      lane_nxt.ang = ang - da;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      lane_r <= lane_nxt;
      side_r <= side_i;
    end
  end

  assign lane_o = lane_r;
  assign side_o = side_r;

endmodule

>>> rtl/dtpy_gain.sv
module dtpy_gain
  import dtpy_pkg::*;
(
  input  logic  clk,
  input  logic  ld_a,
  input  logic  ld_b,
  input  lane_t lane_i,
  input  side_t side_i,
  output lane_t lane_o,
  output side_t side_o
);

  localparam int MAG_W = 51;
  localparam int HI_W  = MAG_W - 32;
  localparam int PHI_W = HI_W + 31;
  localparam int PLO_W = 63;

  logic [MAG_W-1:0]         mag;
  logic [HI_W-1:0]          mag_hi;
  logic [31:0]              mag_lo;
  logic [PHI_W-1:0]         p_hi_nxt, p_hi_r;
  logic [PLO_W-1:0]         p_lo_nxt, p_lo_r;
  logic signed [LANE_W-1:0] zs, w_nxt, w_r;
  side_t                    side_nxt, side_a_r, side_b_r;
  logic [63:0]              lo_rnd;
  lane_t                    lane_nxt, lane_r;

  // Stage A: split the magnitude and take both partial products
  always_comb begin
    mag      = lane_i.x[LANE_W-1] ? '0 : lane_i.x[MAG_W-1:0];
    mag_hi   = mag[MAG_W-1:32];
    mag_lo   = mag[31:0];
    p_hi_nxt = PHI_W'(mag_hi) * PHI_W'(INV_GAIN_Q31);
    p_lo_nxt = PLO_W'(mag_lo) * PLO_W'(INV_GAIN_Q31);
    zs       = {{(LANE_W-DIR_W){side_i.z[DIR_W-1]}}, side_i.z};
    w_nxt    = -(zs <<< FRAC_W);
    side_nxt     = side_i;
    side_nxt.yaw = lane_i.ang;
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      p_hi_r   <= p_hi_nxt;
      p_lo_r   <= p_lo_nxt;
      w_r      <= w_nxt;
      side_a_r <= side_nxt;
    end
  end

  // Stage B: recombine with round half up, set up the pitch lane
  always_comb begin
    lo_rnd       = 64'(p_lo_r) + 64'h4000_0000;
    lane_nxt.x   = LANE_W'({p_hi_r, 1'b0}) + LANE_W'(lo_rnd[63:31]);
    lane_nxt.y   = w_r;
    lane_nxt.ang = '0;
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      lane_r   <= lane_nxt;
      side_b_r <= side_a_r;
    end
  end

  assign lane_o = lane_r;
  assign side_o = side_b_r;

endmodule
